>>> hdl/pgf_pkg.sv
// Package for the point gravity field unit: port words, pipeline word,
// configuration snapshot, register indexes and pipeline stage numbers.
// No dependencies.
package pgf_pkg;

   typedef enum logic [2:0] {
      CSR_POINT_MODE    = 3'd0,
      CSR_STRENGTH      = 3'd1,
      CSR_VEC_X         = 3'd2,
      CSR_VEC_Y         = 3'd3,
      CSR_VEC_Z         = 3'd4,
      CSR_UNIT_DISTANCE = 3'd5,
      CSR_MIN_DIST_SQ   = 3'd6
   } csr_index_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Stage numbers of the pipeline
   localparam int PIPE_DEPTH = 70;
   localparam int SQ_STAGE   = 1;   // squares and constant products
   localparam int SUM_STAGE  = 2;   // squared distance, clamp, directional result
   localparam int SQRT_FIRST = 3;   // first root bit step, also falloff numerator
   localparam int SQRT_BITS  = 33;
   localparam int SCL_INIT   = 4;   // scale overflow check
   localparam int SCL_BITS   = 62;
   localparam int DIR_INIT   = 36;  // direction dividends
   localparam int DIR_BITS   = 31;
   localparam int PROD_STAGE = 68;
   localparam int FIN_STAGE  = 69;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] acc_x;
      logic signed [31:0] acc_y;
      logic signed [31:0] acc_z;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic                    point_mode;
      logic                    falloff;
      logic                    sneg;
      logic [31:0]             smag;
      logic [30:0]             um;
      logic [2:0]              vneg;
      logic [2:0][31:0]        vmag;
      logic [2:0][31:0]        vec;
      logic [31:0]             floor_sq;
   } cfg_type;

   typedef struct packed {
      logic [2:0]              dneg;
      logic [2:0][31:0]        dmag;
      logic [2:0][63:0]        sq;
      logic [61:0]             um2;
      logic [2:0][63:0]        dprod;
      logic [2:0][31:0]        acc_dir;
      logic                    sat_dir;
      logic [65:0]             dsq;
      logic [62:0]             numa;
      logic [62:0]             numb;
      logic [93:0]             num;
      logic [67:0]             qrem;
      logic [32:0]             root;
      logic                    ovf;
      logic [127:0]            srem;
      logic [61:0]             scale;
      logic [2:0][63:0]        drem;
      logic [2:0][30:0]        dir;
      logic [2:0][62:0]        pn;
      logic [2:0][62:0]        pa;
      logic [2:0][62:0]        pb;
      rsp_type                 rsp;
   } item_type;

endpackage

>>> hdl/point_gravity_field_unit.sv
// Point gravity field unit: top level, a 70-stage pipeline with its own
// configuration registers. Depends on pgf_pkg.
//
// Takes one Q16.16 position word per cycle while the pipe advances and
// returns one acceleration word per position, in order. The depth is set by
// the chain in point mode: a 33-step bit-per-stage square root of the squared
// distance followed by a 31-step bit-per-stage divider that forms the unit
// direction; the 62-step inverse-square scale divider runs beside them.
// Throughput is one word per clock while the result side keeps up. When the
// result side stalls, the whole pipe holds, and the entry stage still takes a
// word if it is empty. Configuration writes are registered and are meant for
// an idle pipe.
module point_gravity_field_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  pgf_pkg::req_type                req_word,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output pgf_pkg::rsp_type                rsp_word,
   input  logic                            csr_we,
   input  logic [pgf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pgf_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int N = pgf_pkg::PIPE_DEPTH;

   // Configuration registers
   logic        point_mode_ff;
   logic [31:0] strength_ff, vec_x_ff, vec_y_ff, vec_z_ff, unit_dist_ff, min_dist_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_mode_ff  <= 1'b0;
         strength_ff    <= 32'd642252;
         vec_x_ff       <= 32'd0;
         vec_y_ff       <= 32'hFFFF_0000;
         vec_z_ff       <= 32'd0;
         unit_dist_ff   <= 32'd0;
         min_dist_sq_ff <= 32'd1;
      end else if (csr_we) begin
         unique case (pgf_pkg::csr_index_type'(csr_index))
            pgf_pkg::CSR_POINT_MODE:    point_mode_ff  <= csr_wdata[0];
            pgf_pkg::CSR_STRENGTH:      strength_ff    <= csr_wdata;
            pgf_pkg::CSR_VEC_X:         vec_x_ff       <= csr_wdata;
            pgf_pkg::CSR_VEC_Y:         vec_y_ff       <= csr_wdata;
            pgf_pkg::CSR_VEC_Z:         vec_z_ff       <= csr_wdata;
            pgf_pkg::CSR_UNIT_DISTANCE: unit_dist_ff   <= csr_wdata;
            pgf_pkg::CSR_MIN_DIST_SQ:   min_dist_sq_ff <= csr_wdata;
            default: ;  // unknown index: drop the write
         endcase
      end
   end

   // Derived configuration: magnitudes and signs, used by every stage
   pgf_pkg::cfg_type cfg;

   always_comb begin
      cfg.point_mode = point_mode_ff;
      cfg.falloff    = !unit_dist_ff[31] && (unit_dist_ff != 32'd0);
      cfg.sneg       = strength_ff[31];
      cfg.smag       = strength_ff[31] ? (32'd0 - strength_ff) : strength_ff;
      cfg.um         = unit_dist_ff[30:0];
      cfg.vec[0]     = vec_x_ff;
      cfg.vec[1]     = vec_y_ff;
      cfg.vec[2]     = vec_z_ff;
      for (int i = 0; i < 3; i++) begin
         cfg.vneg[i] = cfg.vec[i][31];
         cfg.vmag[i] = cfg.vec[i][31] ? (32'd0 - cfg.vec[i]) : cfg.vec[i];
      end
      // a zero clamp acts as one so the root never reaches zero
      cfg.floor_sq   = (min_dist_sq_ff == 32'd0) ? 32'd1 : min_dist_sq_ff;
   end

   // Sign a rounded magnitude and clip it to 32 bits; bit 32 flags the clip
   function automatic logic [32:0] fin(input logic [63:0] v, input logic neg);
      logic [63:0] limit;
      logic [31:0] m;
      limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
      if (v > limit) begin
         m = limit[31:0];
         return {1'b1, neg ? (32'd0 - m) : m};
      end
      m = v[31:0];
      return {1'b0, neg ? (32'd0 - m) : m};
   endfunction

   // Entry stage: offsets from position to centre
   function automatic pgf_pkg::item_type first_step(input pgf_pkg::req_type r,
                                                    input pgf_pkg::cfg_type c);
      pgf_pkg::item_type y;
      logic [2:0][31:0]  p;
      logic signed [32:0] d;
      y = '0;
      p[0] = r.pos_x;
      p[1] = r.pos_y;
      p[2] = r.pos_z;
      for (int i = 0; i < 3; i++) begin
         d = $signed({c.vec[i][31], c.vec[i]}) - $signed({p[i][31], p[i]});
         y.dneg[i] = d[32];
         y.dmag[i] = d[32] ? 32'(33'd0 - 33'(d)) : d[31:0];
      end
      return y;
   endfunction

   // Work of stage k on the word leaving stage k-1
   function automatic pgf_pkg::item_type step(input int k, input pgf_pkg::item_type x,
                                              input pgf_pkg::cfg_type c);
      pgf_pkg::item_type y;
      logic [65:0]  sum;
      logic [67:0]  tq;
      logic [63:0]  td;
      logic [127:0] ts;
      logic [93:0]  vf;
      logic [63:0]  vn;
      logic [32:0]  r;
      logic         neg;
      int           b;
      y = x;
      if (k == pgf_pkg::SQ_STAGE) begin
         for (int i = 0; i < 3; i++) begin
            y.sq[i]    = 64'(x.dmag[i]) * 64'(x.dmag[i]);
            y.dprod[i] = 64'(c.vmag[i]) * 64'(c.smag);
         end
         y.um2 = 62'(c.um) * 62'(c.um);
      end
      if (k == pgf_pkg::SUM_STAGE) begin
         sum = 66'(x.sq[0]) + 66'(x.sq[1]) + 66'(x.sq[2]);
         y.dsq = (sum < 66'(c.floor_sq)) ? 66'(c.floor_sq) : sum;
         y.qrem = 68'(y.dsq);
         y.root = '0;
         y.numa = 63'(c.smag) * 63'(x.um2[30:0]);
         y.numb = 63'(c.smag) * 63'(x.um2[61:31]);
         y.sat_dir = 1'b0;
         for (int i = 0; i < 3; i++) begin
            r = fin(64'((65'(x.dprod[i]) + 65'(1 << 15)) >> 16), c.vneg[i] ^ c.sneg);
            y.acc_dir[i] = r[31:0];
            y.sat_dir    = y.sat_dir | r[32];
         end
      end
      if (k == pgf_pkg::SQRT_FIRST) begin
         y.num = 94'(x.numa) + (94'(x.numb) << 31) + 94'(x.dsq >> 1);
      end
      if (k >= pgf_pkg::SQRT_FIRST && k < pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS) begin
         b  = pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS - 1 - k;
         tq = (68'(x.root) << (b + 1)) + (68'(1) << (2 * b));
         if (x.qrem >= tq) begin
            y.qrem = x.qrem - tq;
            y.root = x.root | (33'(1) << b);
         end
      end
      if (k == pgf_pkg::SCL_INIT) begin
         y.ovf   = (128'(x.num) >= (128'(x.dsq) << 62));
         y.srem  = 128'(x.num);
         y.scale = '0;
      end
      if (k > pgf_pkg::SCL_INIT && k <= pgf_pkg::SCL_INIT + pgf_pkg::SCL_BITS) begin
         b  = pgf_pkg::SCL_INIT + pgf_pkg::SCL_BITS - k;
         ts = 128'(x.dsq) << b;
         if (x.srem >= ts) begin
            y.srem  = x.srem - ts;
            y.scale = x.scale | (62'(1) << b);
         end
      end
      if (k == pgf_pkg::DIR_INIT) begin
         for (int i = 0; i < 3; i++) begin
            y.drem[i] = (64'(x.dmag[i]) << 30) + 64'(x.root >> 1);
            y.dir[i]  = '0;
         end
      end
      if (k > pgf_pkg::DIR_INIT && k <= pgf_pkg::DIR_INIT + pgf_pkg::DIR_BITS) begin
         b = pgf_pkg::DIR_INIT + pgf_pkg::DIR_BITS - k;
         for (int i = 0; i < 3; i++) begin
            td = 64'(x.root) << b;
            if (x.drem[i] >= td) begin
               y.drem[i] = x.drem[i] - td;
               y.dir[i]  = x.dir[i] | (31'(1) << b);
            end
         end
      end
      if (k == pgf_pkg::PROD_STAGE) begin
         for (int i = 0; i < 3; i++) begin
            y.pn[i] = 63'(x.dir[i]) * 63'(c.smag);
            y.pa[i] = 63'(x.scale[30:0]) * 63'(x.dir[i]);
            y.pb[i] = 63'(x.scale[61:31]) * 63'(x.dir[i]);
         end
      end
      if (k == pgf_pkg::FIN_STAGE) begin
         y.rsp.saturated = 1'b0;
         for (int i = 0; i < 3; i++) begin
            neg = x.dneg[i] ^ c.sneg;
            vf  = (94'(x.pa[i]) + (94'(x.pb[i]) << 31) + (94'(1) << 29)) >> 30;
            vn  = (64'(x.pn[i]) + (64'(1) << 29)) >> 30;
            if (!c.point_mode) begin
               r = {x.sat_dir, x.acc_dir[i]};
            end else if (c.falloff) begin
               r = fin(vf[63:0], neg);
               if (x.ovf && (x.dir[i] != '0)) begin
                  r = {1'b1, neg ? 32'h8000_0000 : 32'h7FFF_FFFF};
               end
            end else begin
               r = fin(vn, neg);
            end
            y.rsp.saturated = y.rsp.saturated | r[32];
            case (i)
               0:       y.rsp.acc_x = r[31:0];
               1:       y.rsp.acc_y = r[31:0];
               default: y.rsp.acc_z = r[31:0];
            endcase
         end
      end
      return y;
   endfunction

   // Pipeline: valid bits travel beside the words
   pgf_pkg::item_type pipe_ff [N];
   pgf_pkg::item_type pipe_in [N];
   logic [N-1:0]      vld_ff;
   logic              advance;

   // Advance everything when the output slot frees; the entry stage also
   // fills a bubble while the rest holds.
   assign advance   = !vld_ff[N-1] || rsp_ready;
   assign req_ready = advance || !vld_ff[0];

   assign pipe_in[0] = first_step(req_word, cfg);

   for (genvar k = 1; k < N; k++) begin : g_stage
      assign pipe_in[k] = step(k, pipe_ff[k-1], cfg);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (req_ready) begin
            vld_ff[0] <= req_valid;
         end
         if (advance) begin
            vld_ff[N-1:1] <= vld_ff[N-2:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         pipe_ff[0] <= pipe_in[0];
      end
      if (advance) begin
         for (int k = 1; k < N; k++) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign rsp_valid = vld_ff[N-1];
   assign rsp_word  = pipe_ff[N-1].rsp;

   // A word in the next-to-last stage reaches the output on an advance
   a_drain: assert property (@(posedge clock) disable iff (reset)
      advance && vld_ff[N-2] |=> rsp_valid)
      else $error("word lost before the output stage");

   // The root never overshoots the squared distance
   a_root: assert property (@(posedge clock) disable iff (reset)
      vld_ff[pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS - 1] && point_mode_ff |->
         (66'(pipe_ff[pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS - 1].root) *
          66'(pipe_ff[pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS - 1].root)) <=
         pipe_ff[pgf_pkg::SQRT_FIRST + pgf_pkg::SQRT_BITS - 1].dsq)
      else $error("square root above radicand");

   // Unit direction components stay within one in unsigned Q1.30
   a_dir: assert property (@(posedge clock) disable iff (reset)
      vld_ff[pgf_pkg::PROD_STAGE - 1] && point_mode_ff |->
         pipe_ff[pgf_pkg::PROD_STAGE - 1].dir[0] <= 31'h4000_0000 &&
         pipe_ff[pgf_pkg::PROD_STAGE - 1].dir[1] <= 31'h4000_0000 &&
         pipe_ff[pgf_pkg::PROD_STAGE - 1].dir[2] <= 31'h4000_0000)
      else $error("direction component above one");

   // A stalled entry word holds its place
   a_hold: assert property (@(posedge clock) disable iff (reset)
      vld_ff[0] && !req_ready |=> vld_ff[0])
      else $error("entry word dropped during stall");

endmodule

>>> verif/point_gravity_field_checker.sv
// Checker for the point gravity field unit: keeps its own copy of the registers,
// predicts each acceleration word and compares it with the block's result words.
// Depends on pgf_pkg.
module point_gravity_field_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  pgf_pkg::req_type                req_word,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  pgf_pkg::rsp_type                rsp_word,
   input  logic                            csr_we,
   input  logic [pgf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [pgf_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              pending,
   output int                              checked
);

   logic        mode_q;
   logic [31:0] strength_q, unit_q, floor_q;
   logic [31:0] centre_q [3];

   pgf_pkg::rsp_type expected_acc [$];
   int mismatches;

   assign fail_count = mismatches;

   // round a magnitude by 2^sh, apply sign, clip to 32 bits
   function automatic logic [31:0] round_clip(logic [255:0] m, int sh, logic neg,
                                              inout logic sat);
      logic [255:0] v;
      logic [255:0] lim;
      v   = (m + (256'd1 << (sh - 1))) >> sh;
      lim = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
      if (v > lim) begin
         v   = lim;
         sat = 1'b1;
      end
      return neg ? -v[31:0] : v[31:0];
   endfunction

   function automatic logic [63:0] isqrt66(logic [65:0] v);
      logic [67:0] r;
      logic [67:0] c;
      r = '0;
      for (int b = 33; b >= 0; b--) begin
         c = r | (68'd1 << b);
         if (c * c <= {2'b0, v}) r = c;
      end
      return r[63:0];
   endfunction

   function automatic pgf_pkg::rsp_type field_at(pgf_pkg::req_type p);
      pgf_pkg::rsp_type res;
      logic [31:0]  acc [3];
      logic signed [33:0] d;
      logic [33:0]  dmag [3];
      logic         dneg [3];
      logic [255:0] dsq, fl, num, scale, dir [3], smag, r;
      logic signed [31:0] s, c, u;
      logic sat;
      logic signed [31:0] pos [3];
      sat = 1'b0;
      s = strength_q;
      smag = s < 0 ? -{{224{1'b1}}, s} : {224'd0, s};
      pos[0] = p.pos_x; pos[1] = p.pos_y; pos[2] = p.pos_z;
      if (!mode_q) begin
         for (int i = 0; i < 3; i++) begin
            c = centre_q[i];
            acc[i] = round_clip((c < 0 ? 256'(-64'(c)) : 256'(c)) * smag, 16,
                                (c < 0) != (s < 0), sat);
         end
      end else begin
         dsq = '0;
         for (int i = 0; i < 3; i++) begin
            d = 34'(signed'(centre_q[i])) - 34'(pos[i]);
            dneg[i] = d < 0;
            dmag[i] = dneg[i] ? -d : d;
            dsq += 256'(dmag[i]) * 256'(dmag[i]);
         end
         fl = floor_q == 0 ? 256'd1 : 256'(floor_q);
         if (dsq < fl) dsq = fl;
         r = 256'(isqrt66(dsq[65:0]));
         for (int i = 0; i < 3; i++)
            dir[i] = ((256'(dmag[i]) << 30) + (r >> 1)) / r;
         u = unit_q;
         if (u <= 0) begin
            for (int i = 0; i < 3; i++)
               acc[i] = round_clip(dir[i] * smag, 30, dneg[i] != (s < 0), sat);
         end else begin
            num = smag * 256'(u) * 256'(u);
            scale = (num + (dsq >> 1)) / dsq;
            for (int i = 0; i < 3; i++)
               acc[i] = round_clip(scale * dir[i], 30, dneg[i] != (s < 0), sat);
         end
      end
      res.acc_x = acc[0];
      res.acc_y = acc[1];
      res.acc_z = acc[2];
      res.saturated = sat;
      return res;
   endfunction

   always @(posedge clock) begin
      pgf_pkg::rsp_type want;
      if (reset) begin
         mode_q      <= 1'b0;
         strength_q  <= 32'd642252;
         centre_q[0] <= 32'd0;
         centre_q[1] <= 32'hFFFF_0000;
         centre_q[2] <= 32'd0;
         unit_q      <= 32'd0;
         floor_q     <= 32'd1;
         expected_acc.delete();
         mismatches  <= 0;
         checked     <= 0;
         pending     <= 0;
      end else begin
         if (csr_we) begin
            case (pgf_pkg::csr_index_type'(csr_index))
               pgf_pkg::CSR_POINT_MODE:    mode_q      <= csr_wdata[0];
               pgf_pkg::CSR_STRENGTH:      strength_q  <= csr_wdata;
               pgf_pkg::CSR_VEC_X:         centre_q[0] <= csr_wdata;
               pgf_pkg::CSR_VEC_Y:         centre_q[1] <= csr_wdata;
               pgf_pkg::CSR_VEC_Z:         centre_q[2] <= csr_wdata;
               pgf_pkg::CSR_UNIT_DISTANCE: unit_q      <= csr_wdata;
               pgf_pkg::CSR_MIN_DIST_SQ:   floor_q     <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) expected_acc = {expected_acc, field_at(req_word)};
         if (rsp_valid && rsp_ready) begin
            checked <= checked + 1;
            if (expected_acc.size() == 0) begin
               if (mismatches < 10) $display("unexpected result word %h", rsp_word);
               mismatches <= mismatches + 1;
            end else begin
               want = expected_acc.pop_front();
               if (want !== rsp_word) begin
                  if (mismatches < 10)
                     $display("mismatch: exp %h %h %h s%b got %h %h %h s%b",
                              want.acc_x, want.acc_y, want.acc_z, want.saturated,
                              rsp_word.acc_x, rsp_word.acc_y, rsp_word.acc_z,
                              rsp_word.saturated);
                  mismatches <= mismatches + 1;
               end
            end
         end
         pending <= expected_acc.size();
      end
   end
endmodule

>>> verif/point_gravity_field_unit_test.sv
// Testbench top for the point gravity field unit: clock, reset, configuration
// phases, position stimulus with random idling and the verdict.
// Depends on pgf_pkg, point_gravity_field_unit and point_gravity_field_checker.
module point_gravity_field_unit_test;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pgf_pkg::req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pgf_pkg::rsp_type rsp_word;
   logic csr_we = 1'b0;
   logic [pgf_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [pgf_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count, pending, checked;
   int send_idle = 0, recv_idle = 0;   // idle percentages
   bit hold_req = 1'b0;                // toggle to start a long receiver hold-off
   bit hold_seen = 1'b0;
   int hold_left = 0;                  // hold-off cycles still to go
   int cycles = 0;
   int sent = 0;

   localparam int LIMIT = 400000;
   localparam int HOLD_CYCLES = 400;
   localparam logic [pgf_pkg::CSR_INDEX_W-1:0] UNUSED_INDEX = 3'd7;

   always #1 clock = ~clock;

   point_gravity_field_unit uut (.*);

   point_gravity_field_checker check (.*);

   // Watchdog: give up well past the slowest correct run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here.
   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   task automatic write_reg(logic [pgf_pkg::CSR_INDEX_W-1:0] idx,
                            logic [pgf_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Drain: wait until every expected word has come back, then let the pipe settle.
   task automatic drain();
      while (pending != 0) @(negedge clock);
      repeat (pgf_pkg::PIPE_DEPTH + 5) @(negedge clock);
   endtask

   // Offer one position word; hold it until it is taken.
   task automatic send_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= '{pos_x: x, pos_y: y, pos_z: z};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic stop_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Random coordinate, mostly near the centre, sometimes anywhere.
   function automatic logic [31:0] near(logic [31:0] c);
      case ($urandom_range(3))
         0: return $urandom;
         1: return c + $urandom_range(0, 32) - 16;
         default: return c + ($urandom_range(0, 1 << 22) - (1 << 21));
      endcase
   endfunction

   // Centre as the checker last saw it, so random points cluster around it.
   function automatic logic [31:0] uut_centre(int i);
      return check.centre_q[i];
   endfunction

   task automatic random_config();
      write_reg(pgf_pkg::CSR_POINT_MODE, 32'($urandom_range(3) != 0));
      case ($urandom_range(3))
         0: write_reg(pgf_pkg::CSR_STRENGTH, $urandom);
         1: write_reg(pgf_pkg::CSR_STRENGTH, $urandom_range(0, 1 << 20) - (1 << 19));
         2: write_reg(pgf_pkg::CSR_STRENGTH, 32'h7FFF_FFFF);
         default: write_reg(pgf_pkg::CSR_STRENGTH, 32'h8000_0000);
      endcase
      write_reg(pgf_pkg::CSR_VEC_X, $urandom_range(1) ? $urandom : 32'(65536 * 3));
      write_reg(pgf_pkg::CSR_VEC_Y, $urandom);
      write_reg(pgf_pkg::CSR_VEC_Z, $urandom_range(1) ? $urandom : 32'hFFFF_0000);
      case ($urandom_range(3))
         0: write_reg(pgf_pkg::CSR_UNIT_DISTANCE, 0);
         1: write_reg(pgf_pkg::CSR_UNIT_DISTANCE, $urandom);
         2: write_reg(pgf_pkg::CSR_UNIT_DISTANCE, 32'h7FFF_FFFF);
         default: write_reg(pgf_pkg::CSR_UNIT_DISTANCE, $urandom_range(1, 1 << 20));
      endcase
      case ($urandom_range(2))
         0: write_reg(pgf_pkg::CSR_MIN_DIST_SQ, 0);
         1: write_reg(pgf_pkg::CSR_MIN_DIST_SQ, 32'hFFFF_FFFF);
         default: write_reg(pgf_pkg::CSR_MIN_DIST_SQ, $urandom);
      endcase
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle = 33;
      recv_idle = 69;

      // Directed: reset setting in directional mode, position ignored.
      send_pos(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_pos(0, 0, 0);
      stop_sending();
      drain();

      // Directional extremes: full-scale negative strength with a negative, a positive and a zero component.
      write_reg(pgf_pkg::CSR_STRENGTH, 32'h8000_0000);
      write_reg(pgf_pkg::CSR_VEC_X, 32'h8000_0000);
      write_reg(pgf_pkg::CSR_VEC_Y, 32'h7FFF_FFFF);
      write_reg(pgf_pkg::CSR_VEC_Z, 0);
      send_pos(1, 2, 3);
      stop_sending();
      drain();

      // Point mode: at the centre with a zero clamp register, then extremes.
      write_reg(pgf_pkg::CSR_POINT_MODE, 1);
      write_reg(pgf_pkg::CSR_MIN_DIST_SQ, 0);
      write_reg(pgf_pkg::CSR_STRENGTH, 32'd642252);
      send_pos(32'h8000_0000, 32'h7FFF_FFFF, 0);
      send_pos(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
      send_pos(32'h8000_0001, 32'h7FFF_FFFE, 1);
      stop_sending();
      drain();
      write_reg(pgf_pkg::CSR_VEC_X, 32'h7FFF_FFFF);
      write_reg(pgf_pkg::CSR_VEC_Y, 32'h7FFF_FFFF);
      write_reg(pgf_pkg::CSR_VEC_Z, 32'h8000_0000);
      send_pos(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
      send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
      send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFE, 32'h8000_0000);
      stop_sending();
      drain();

      // Falloff with a big clamp and full-scale unit distance.
      write_reg(pgf_pkg::CSR_UNIT_DISTANCE, 32'h7FFF_FFFF);
      write_reg(pgf_pkg::CSR_MIN_DIST_SQ, 32'hFFFF_FFFF);
      write_reg(pgf_pkg::CSR_STRENGTH, 32'h7FFF_FFFF);
      send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pos(32'h7FFF_FFF0, 32'h7FFF_FFFF, 32'h8000_0000);
      send_pos(0, 0, 0);
      stop_sending();
      drain();
      write_reg(UNUSED_INDEX, 32'hDEAD_BEEF);   // unused index: dropped

      // Random phases: three idling regimes, each with four settings.
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 33 : (ph == 1) ? 69 : 0;
         recv_idle = (ph == 0) ? 69 : (ph == 1) ? 33 : 0;
         for (int k = 0; k < 4; k++) begin
            random_config();
            if (k == 1) hold_req = !hold_req;   // fill the pipe and stall its input
            for (int n = 0; n < 115; n++) begin
               send_pos(near(uut_centre(0)), near(uut_centre(1)), near(uut_centre(2)));
            end
            stop_sending();
            drain();
         end
      end

      $display("Covered %0d positions, %0d results compared: both modes, falloff, clamps,",
               sent, checked);
      $display("saturation, three idle mixes, a long result stall and drains between settings.");
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
